>>> rtl/mdpb_pkg.sv
// shared types and constants for the midi driven pwm bank
package mdpb_pkg;

  // default bank size
  localparam int unsigned CHANNELS_DEF = 32;
  localparam int unsigned STEPS_DEF    = 128;

  // fixed field widths
  localparam int unsigned PIN_BITS = 32;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned NOTE_W   = 8;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  // usb-midi event codes on cable 0
  localparam logic [CODE_W-1:0] EV_NOTE_OFF = 8'h08;
  localparam logic [CODE_W-1:0] EV_NOTE_ON  = 8'h09;

  // one midi event handed to the duty bank
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] code;
    logic [NOTE_W-1:0] note;
    logic [DUTY_W-1:0] velocity;
  } duty_evt_t;

endpackage

>>> rtl/mdpb_duty_bank.sv
// per-channel duty registers and the parallel phase compare
module mdpb_duty_bank
  import mdpb_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned PHASE_W  = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  duty_evt_t           evt_i,
  input  logic [PHASE_W-1:0]  phase_i,
  output logic [PIN_BITS-1:0] pin_word_o
);

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [DUTY_W-1:0] duty_q [CHANNELS];
  logic              in_range;
  logic [ChW-1:0]    ch_idx;
  logic [DUTY_W-1:0] phase_ext;

  // channel decode
  assign in_range  = evt_i.note < NOTE_W'(CHANNELS);
  assign ch_idx    = evt_i.note[ChW-1:0];
  assign phase_ext = DUTY_W'(phase_i);

  // duty update on note-on and note-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(CHANNELS); k++) begin
        duty_q[k] <= '0;
      end
    end else if (evt_i.en && in_range) begin
      if (evt_i.code == EV_NOTE_ON) begin
        duty_q[ch_idx] <= evt_i.velocity;
      end else if (evt_i.code == EV_NOTE_OFF) begin
        duty_q[ch_idx] <= '0;
      end
    end
  end

  // one compare per pin, unused pins stay low
  for (genvar k = 0; k < PIN_BITS; k++) begin : g_pin
    if (k < CHANNELS) begin : g_used
      assign pin_word_o[k] = phase_ext < duty_q[k];
    end else begin : g_unused
      assign pin_word_o[k] = 1'b0;
    end
  end

endmodule

>>> rtl/mdpb_phase_ctr.sv
// shared phase counter, wraps after the last step
module mdpb_phase_ctr
  import mdpb_pkg::*;
#(
  parameter int unsigned STEPS   = STEPS_DEF,
  parameter int unsigned PHASE_W = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  output logic [PHASE_W-1:0] phase_o
);

  localparam logic [PHASE_W-1:0] PhaseLast = PHASE_W'(STEPS - 1);

  logic [PHASE_W-1:0] phase_q;
  logic [PHASE_W-1:0] phase_d;

  // advance modulo steps
  always_comb begin
    phase_d = phase_q;
    if (tick_i) begin
      phase_d = (phase_q == PhaseLast) ? '0 : phase_q + PHASE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

>>> rtl/midi_driven_pwm_bank_top.sv
// top level of the midi driven pwm bank
//
// A bank of CHANNELS pwm channels sharing one phase counter of STEPS steps.
// A midi event transfer (req_type 1) with a note below CHANNELS sets that
// channel's duty: note-on (code 9) loads the velocity, note-off (code 8)
// loads zero, anything else is dropped; events give no output transfer.
// A tick transfer (req_type 0) gives one output transfer whose bit k is set
// when the phase is below channel k's duty, then the phase advances; a duty
// at or above STEPS keeps its pin on. Each item is held in the input register
// and the duty compare runs combinationally into the result register; a tick
// transfer passes the input register and then the result register before its
// pin word is presented. One item is taken every cycle unless input stalls.
// A tick waits in the input register, and the input stalls, only while a
// stalled pin word still holds the result register; events retire without
// waiting. No clearing pass is needed after reset.
module midi_driven_pwm_bank_top
  import mdpb_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned STEPS    = STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [CODE_W-1:0]   event_code_i,
  input  logic [NOTE_W-1:0]   note_i,
  input  logic [DUTY_W-1:0]   velocity_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PIN_BITS-1:0] pin_word_o
);

  localparam int unsigned PhaseW = $clog2(STEPS);

  // input register
  logic              s1_valid_q;
  logic              s1_req_q;
  logic [CODE_W-1:0] s1_code_q;
  logic [NOTE_W-1:0] s1_note_q;
  logic [DUTY_W-1:0] s1_vel_q;

  // output register
  logic                out_valid_q;
  logic [PIN_BITS-1:0] pin_word_q;

  logic                out_free;
  logic                s1_tick;
  logic                s1_done;
  logic                in_xfer;
  logic [PhaseW-1:0]   phase;
  logic [PIN_BITS-1:0] pin_word;
  duty_evt_t           evt;

  // stage flow: events always retire, ticks need room in the output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_tick    = s1_valid_q && (s1_req_q == REQ_TICK);
  assign s1_done    = s1_valid_q && ((s1_req_q == REQ_EVENT) || out_free);
  assign in_stall_o = s1_valid_q && !s1_done;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q  <= req_type_i;
      s1_code_q <= event_code_i;
      s1_note_q <= note_i;
      s1_vel_q  <= velocity_i;
    end
  end

  // event handed to the duty bank when it retires
  always_comb begin
    evt          = '0;
    evt.en       = s1_done && (s1_req_q == REQ_EVENT);
    evt.code     = s1_code_q;
    evt.note     = s1_note_q;
    evt.velocity = s1_vel_q;
  end

  mdpb_duty_bank #(
    .CHANNELS (CHANNELS),
    .PHASE_W  (PhaseW)
  ) u_duty_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt),
    .phase_i    (phase),
    .pin_word_o (pin_word)
  );

  mdpb_phase_ctr #(
    .STEPS   (STEPS),
    .PHASE_W (PhaseW)
  ) u_phase_ctr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (s1_tick && out_free),
    .phase_o (phase)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_tick && out_free) begin
      pin_word_q <= pin_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pin_word_o  = pin_word_q;

endmodule
